### rtl/battery_soc_from_voltage_curve_core_defines.svh
// Assertion macros for the state-of-charge lookup pipeline.
`ifndef BATTERY_SOC_FROM_VOLTAGE_CURVE_CORE_DEFINES_SVH
`define BATTERY_SOC_FROM_VOLTAGE_CURVE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSOC_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("State-of-charge pipeline check failed.");

// The consequent must hold in the cycle after the antecedent.
`define BSOC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("State-of-charge pipeline check failed.");

`endif

### rtl/bsoc_pkg.sv
// Package with the curve tables and stage payload types of the state-of-charge lookup.
package bsoc_pkg;

	localparam logic [15:0] LOW_LIMIT_MV   = 16'd3150;
	localparam logic [15:0] HIGH_LIMIT_MV  = 16'd4250;
	localparam logic [15:0] CURVE_FIRST_MV = 16'd3200;
	localparam logic [15:0] CURVE_LAST_MV  = 16'd4200;
	localparam logic [6:0]  PCT_EMPTY      = 7'd0;
	localparam logic [6:0]  PCT_FULL       = 7'd100;
	localparam int          NUM_SEGMENTS   = 10;
	localparam int          RECIP_SHIFT    = 13;

	typedef struct packed {
		logic       in_range;
		logic       flat;
		logic [6:0] pct;
		logic [3:0] seg;
		logic [7:0] off;
	} seg_t;

	typedef struct packed {
		logic        in_range;
		logic        flat;
		logic [6:0]  pct;
		logic [3:0]  seg;
		logic [12:0] x;
	} num_t;

	typedef struct packed {
		logic        in_range;
		logic        flat;
		logic [6:0]  pct;
		logic [3:0]  seg;
		logic [12:0] x;
		logic [3:0]  q;
	} quo_t;

	function automatic logic [12:0] seg_lo_mv(logic [3:0] seg);
		logic [12:0] r;
		unique case (seg)
			4'd0:    r = 13'd3200;
			4'd1:    r = 13'd3350;
			4'd2:    r = 13'd3500;
			4'd3:    r = 13'd3600;
			4'd4:    r = 13'd3700;
			4'd5:    r = 13'd3780;
			4'd6:    r = 13'd3860;
			4'd7:    r = 13'd3950;
			4'd8:    r = 13'd4050;
			4'd9:    r = 13'd4150;
			default: r = 13'd4200;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] seg_den(logic [3:0] seg);
		logic [7:0] r;
		unique case (seg)
			4'd0, 4'd1:             r = 8'd150;
			4'd2, 4'd3, 4'd7, 4'd8: r = 8'd100;
			4'd4, 4'd5:             r = 8'd80;
			4'd6:                   r = 8'd90;
			default:                r = 8'd50;
		endcase
		return r;
	endfunction

	function automatic logic [3:0] seg_dp(logic [3:0] seg);
		logic [3:0] r;
		unique case (seg)
			4'd0:             r = 4'd5;
			4'd1:             r = 4'd7;
			4'd2, 4'd8:       r = 4'd8;
			4'd3, 4'd4, 4'd5: r = 4'd15;
			4'd6:             r = 4'd13;
			4'd7:             r = 4'd10;
			default:          r = 4'd4;
		endcase
		return r;
	endfunction

	function automatic logic [6:0] seg_base(logic [3:0] seg);
		logic [6:0] r;
		unique case (seg)
			4'd0:    r = 7'd0;
			4'd1:    r = 7'd5;
			4'd2:    r = 7'd12;
			4'd3:    r = 7'd20;
			4'd4:    r = 7'd35;
			4'd5:    r = 7'd50;
			4'd6:    r = 7'd65;
			4'd7:    r = 7'd78;
			4'd8:    r = 7'd88;
			default: r = 7'd96;
		endcase
		return r;
	endfunction

	// Floor of 2^RECIP_SHIFT over twice the segment width.
	function automatic logic [6:0] seg_recip(logic [3:0] seg);
		logic [6:0] r;
		unique case (seg)
			4'd0, 4'd1:             r = 7'd27;
			4'd2, 4'd3, 4'd7, 4'd8: r = 7'd40;
			4'd4, 4'd5:             r = 7'd51;
			4'd6:                   r = 7'd45;
			default:                r = 7'd81;
		endcase
		return r;
	endfunction

endpackage

### rtl/bsoc_segment.sv
// First stage: range check, segment search and offset into the segment.
module bsoc_segment (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_i,
	output logic                ready_o,
	input  logic [15:0]         voltage_mv,
	output logic                valid_o,
	input  logic                ready_i,
	output bsoc_pkg::seg_t      dout
);

	logic           valid_s1;
	bsoc_pkg::seg_t data_s1;
	bsoc_pkg::seg_t next;
	logic [3:0]     seg;
	logic [15:0]    diff;

	always_comb begin
		seg = 4'd0;
		for (int k = 1; k < bsoc_pkg::NUM_SEGMENTS; k++) begin
			if (voltage_mv > {3'b000, bsoc_pkg::seg_lo_mv(4'(k))}) begin
				seg = 4'(k);
			end
		end
		diff = voltage_mv - {3'b000, bsoc_pkg::seg_lo_mv(seg)};
		next.in_range = (voltage_mv >= bsoc_pkg::LOW_LIMIT_MV) &&
			(voltage_mv <= bsoc_pkg::HIGH_LIMIT_MV);
		next.seg = seg;
		next.off = diff[7:0];
		next.flat = 1'b1;
		next.pct = bsoc_pkg::PCT_EMPTY;
		if (next.in_range) begin
			if (voltage_mv > bsoc_pkg::CURVE_LAST_MV) begin
				next.pct = bsoc_pkg::PCT_FULL;
			end else if (voltage_mv > bsoc_pkg::CURVE_FIRST_MV) begin
				next.flat = 1'b0;
			end
		end
	end

	assign ready_o = !valid_s1 || ready_i;
	assign valid_o = valid_s1;
	assign dout    = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_o) begin
			valid_s1 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_o && valid_i) begin
			data_s1 <= next;
		end
	end

endmodule

### rtl/bsoc_scale.sv
// Second and third stages: rounded numerator, then reciprocal multiply for the quotient estimate.
module bsoc_scale (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_i,
	output logic                ready_o,
	input  bsoc_pkg::seg_t      din,
	output logic                valid_o,
	input  logic                ready_i,
	output bsoc_pkg::quo_t      dout
);

	logic           valid_s2;
	logic           valid_s3;
	logic           ready_s2;
	bsoc_pkg::num_t data_s2;
	bsoc_pkg::quo_t data_s3;
	logic [11:0]    num;
	logic [12:0]    x;
	logic [19:0]    prod;

	assign num  = 12'(din.off * bsoc_pkg::seg_dp(din.seg));
	assign x    = {num, 1'b0} + {5'b00000, bsoc_pkg::seg_den(din.seg)};
	assign prod = 20'(data_s2.x * bsoc_pkg::seg_recip(data_s2.seg));

	assign ready_s2 = !valid_s3 || ready_i;
	assign ready_o  = !valid_s2 || ready_s2;
	assign valid_o  = valid_s3;
	assign dout     = data_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_o) begin
				valid_s2 <= valid_i;
			end
			if (ready_s2) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_o && valid_i) begin
			data_s2.in_range <= din.in_range;
			data_s2.flat     <= din.flat;
			data_s2.pct      <= din.pct;
			data_s2.seg      <= din.seg;
			data_s2.x        <= x;
		end
		if (ready_s2 && valid_s2) begin
			data_s3.in_range <= data_s2.in_range;
			data_s3.flat     <= data_s2.flat;
			data_s3.pct      <= data_s2.pct;
			data_s3.seg      <= data_s2.seg;
			data_s3.x        <= data_s2.x;
			data_s3.q        <= prod[bsoc_pkg::RECIP_SHIFT +: 4];
		end
	end

endmodule

### rtl/bsoc_round.sv
// Last stage: quotient correction, base percentage and the output register.
`include "battery_soc_from_voltage_curve_core_defines.svh"

module bsoc_round (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_i,
	output logic                ready_o,
	input  bsoc_pkg::quo_t      din,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [6:0]          out_pct,
	output logic                out_in_range
);

	logic        valid_s4;
	logic [6:0]  pct_s4;
	logic        in_range_s4;
	logic [8:0]  den2;
	logic [4:0]  q_inc;
	logic [13:0] step;
	logic [13:0] bound;
	logic [3:0]  q_fix;
	logic [6:0]  pct;

	assign den2  = {bsoc_pkg::seg_den(din.seg), 1'b0};
	assign q_inc = {1'b0, din.q} + 5'd1;
	assign step  = 14'(q_inc * den2);
	assign bound = step + {5'b00000, den2};
	assign q_fix = (step <= {1'b0, din.x}) ? 4'(q_inc) : din.q;
	assign pct   = din.flat ? din.pct : bsoc_pkg::seg_base(din.seg) + {3'b000, q_fix};

	assign ready_o      = !valid_s4 || out_ready;
	assign out_valid    = valid_s4;
	assign out_pct      = pct_s4;
	assign out_in_range = in_range_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (ready_o) begin
			valid_s4 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_o && valid_i) begin
			pct_s4      <= pct;
			in_range_s4 <= din.in_range;
		end
	end

	// The reciprocal estimate is never more than one below the true quotient.
	`BSOC_ASSERT_SAME(a_quot_window, valid_i && !din.flat, {1'b0, din.x} < bound)
	`BSOC_ASSERT_SAME(a_out_of_range_zero, valid_s4 && !in_range_s4, pct_s4 == 7'd0)
	`BSOC_ASSERT_SAME(a_pct_limit, valid_s4, pct_s4 <= bsoc_pkg::PCT_FULL)

endmodule

### rtl/battery_soc_from_voltage_curve_core.sv
// Top level of the battery state-of-charge lookup from a voltage curve.
// One voltage sample in millivolts enters per transaction on the slave side and one
// state-of-charge result leaves per transaction on the master side, in order. The block
// is a four-stage pipeline (segment search, numerator, reciprocal multiply, correction
// and output register), so a sample can be accepted in every cycle while the master side
// is not stalled; no stage holds an iterative unit, so the rate is then one sample per cycle.
// Results are the curve value rounded half up; samples outside 3150 to 4250 mV give
// a percentage of zero with the in-range flag clear.
module battery_soc_from_voltage_curve_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [15:0] voltage_mv
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // [6:0] soc_percent, [7] zero
	output logic [0:0]  m_tuser   // [0] in_range
);

	logic           seg_valid;
	logic           seg_ready;
	bsoc_pkg::seg_t seg_data;
	logic           quo_valid;
	logic           quo_ready;
	bsoc_pkg::quo_t quo_data;
	logic [6:0]     soc_percent;
	logic           in_range;

	bsoc_segment u_segment (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_i    (s_tvalid),
		.ready_o    (s_tready),
		.voltage_mv (s_tdata),
		.valid_o    (seg_valid),
		.ready_i    (seg_ready),
		.dout       (seg_data)
	);

	bsoc_scale u_scale (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_i (seg_valid),
		.ready_o (seg_ready),
		.din     (seg_data),
		.valid_o (quo_valid),
		.ready_i (quo_ready),
		.dout    (quo_data)
	);

	bsoc_round u_round (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_i      (quo_valid),
		.ready_o      (quo_ready),
		.din          (quo_data),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_pct      (soc_percent),
		.out_in_range (in_range)
	);

	assign m_tdata = {1'b0, soc_percent};
	assign m_tuser = in_range;

endmodule
